[rtl/gbpl_pkg.sv]
// ----------------------------------------------------------------------------
// Gain bucket priority list package
// Command, status and sequencer state codes shared by the block.
// ----------------------------------------------------------------------------
package gbpl_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_MOVE  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_ABSENT    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DECIDE,
    S_UNLINK,
    S_FIXUP,
    S_SCAN,
    S_LINK_RD,
    S_LINK,
    S_DONE
  } state_e;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned IdW     = 10;
  localparam int unsigned GainW   = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 11;

endpackage

[rtl/gain_bucket_priority_list.sv]
// ----------------------------------------------------------------------------
// Gain bucket priority list
// Each command reads its cell's words, then decides: a query or a refused
// command returns its result; a push links the cell into its bucket; a pop
// unlinks the head of the top bucket, a move its cell, and both scan down past
// empty gain levels, a move then relinking its cell in the new bucket. One
// command at a time: in_stall_o is high until the result leaves. Reset clears
// count, top gain, bucket flags at once, presence cell by cell before any beat.
// ----------------------------------------------------------------------------
module gain_bucket_priority_list #(
  parameter int unsigned NUM_CELLS = 1024,
  parameter int unsigned MAX_GAIN  = 63
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [gbpl_pkg::CmdW-1:0]       cmd_i,
  input  logic [gbpl_pkg::IdW-1:0]        cell_id_i,
  input  logic signed [gbpl_pkg::GainW-1:0] gain_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gbpl_pkg::IdW-1:0]        result_cell_o,
  output logic                            found_o,
  output logic [gbpl_pkg::StatusW-1:0]    status_o,
  output logic [gbpl_pkg::CountW-1:0]     total_count_o
);
  import gbpl_pkg::*;

  localparam int unsigned NB = 2 * MAX_GAIN + 1;
  localparam int unsigned BW = $clog2(NB);
  localparam int unsigned CW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int unsigned KW = $clog2(NUM_CELLS + 1);
  localparam int unsigned TW = ((IdW > CW) ? IdW : CW) + 1;
  localparam int unsigned XW = ((GainW > BW) ? GainW : BW) + 1;

  logic [CW-1:0] head_mem [NB];
  logic [CW:0]   next_mem [NUM_CELLS];
  logic [CW-1:0] prev_mem [NUM_CELLS];
  logic [BW:0]   gb_mem   [NUM_CELLS];
  logic [NB-1:0] nonempty_q;

  state_e state_q, state_d;
  cmd_e cmd_q;
  logic [CW-1:0] c_q;
  logic [CW-1:0] clr_q;
  logic [BW-1:0] nb_q, ob_q, top_q;
  logic [BW:0] scan_q;
  logic [KW-1:0] cnt_q;
  logic [CW-1:0] hd_q, pv_q;
  logic [CW:0] nx_q;
  logic valid_id_q;
  logic [IdW-1:0] res_cell_q;
  logic found_q;
  logic [StatusW-1:0] status_q;

  logic accept;
  logic [CW-1:0] sel_c;
  logic signed [XW-1:0] gx;
  logic [BW-1:0] in_b;
  logic [BW-1:0] ub;
  logic [BW-1:0] hd_addr;
  logic hnx;
  logic [TW-1:0] id_ext;
  logic in_range;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign result_cell_o = res_cell_q;
  assign found_o = found_q;
  assign status_o = status_q;
  assign total_count_o = CountW'(cnt_q);

  assign id_ext   = TW'(cell_id_i);
  assign in_range = id_ext < TW'(NUM_CELLS);

  always_comb begin
    gx = XW'(gain_i);
    if (gx > $signed(XW'(MAX_GAIN))) gx = $signed(XW'(MAX_GAIN));
    if (gx < -$signed(XW'(MAX_GAIN))) gx = -$signed(XW'(MAX_GAIN));
    in_b = BW'(gx + $signed(XW'(MAX_GAIN)));
  end

  assign sel_c = c_q;
  assign hnx   = nx_q[CW];
  assign ub    = (cmd_q == CMD_POP) ? top_q : scan_q[BW-1:0];

  always_comb begin
    case (state_q)
      S_LINK_RD: hd_addr = nb_q;
      S_UNLINK:  hd_addr = ub;
      default:   hd_addr = top_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (clr_q == CW'(NUM_CELLS - 1)) state_d = S_IDLE;
      S_IDLE:    if (in_valid_i) state_d = S_READ;
      S_READ:    state_d = S_DECIDE;
      S_DECIDE: begin
        case (cmd_q)
          CMD_PUSH:  state_d = (scan_q[BW] || !valid_id_q) ? S_DONE : S_LINK_RD;
          CMD_POP:   state_d = (cnt_q == '0) ? S_DONE : S_UNLINK;
          CMD_MOVE:  state_d = (valid_id_q && scan_q[BW]) ? S_UNLINK : S_DONE;
          default:   state_d = S_DONE;
        endcase
      end
      S_UNLINK:  state_d = S_FIXUP;
      S_FIXUP:   state_d = S_SCAN;
      S_SCAN: begin
        if (top_q == '0 || nonempty_q[top_q])
          state_d = (cmd_q == CMD_MOVE) ? S_LINK_RD : S_DONE;
      end
      S_LINK_RD: state_d = S_LINK;
      S_LINK:    state_d = S_DONE;
      S_DONE:    if (!out_stall_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // memories: registered reads
  always_ff @(posedge clk_i) begin
    hd_q <= head_mem[hd_addr];
    nx_q <= next_mem[sel_c];
    pv_q <= prev_mem[sel_c];
    scan_q <= gb_mem[sel_c];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_CLEAR: gb_mem[clr_q] <= '0;
      S_IDLE: if (accept) begin
        cmd_q <= cmd_e'(cmd_i);
        c_q <= CW'(cell_id_i);
        valid_id_q <= in_range;
        nb_q <= in_b;
        res_cell_q <= cell_id_i;
        found_q <= 1'b0;
        status_q <= ST_OK;
      end
      S_DECIDE: begin
        case (cmd_q)
          CMD_PUSH: if (scan_q[BW] || !valid_id_q) status_q <= ST_DUPLICATE;
          CMD_POP: begin
            if (cnt_q == '0) status_q <= ST_EMPTY;
            else begin
              c_q <= hd_q;
              res_cell_q <= IdW'(hd_q);
            end
          end
          CMD_MOVE: if (!(valid_id_q && scan_q[BW])) status_q <= ST_ABSENT;
          default: found_q <= valid_id_q && scan_q[BW];
        endcase
      end
      S_UNLINK: begin
        ob_q <= ub;
      end
      S_FIXUP: begin
        if (hd_q == c_q) begin
          if (hnx) head_mem[ob_q] <= nx_q[CW-1:0];
        end else begin
          next_mem[pv_q] <= nx_q;
          if (hnx) prev_mem[nx_q[CW-1:0]] <= pv_q;
        end
        gb_mem[c_q] <= {1'b0, ob_q};
      end
      S_LINK: begin
        next_mem[c_q] <= {nonempty_q[nb_q], hd_q};
        if (nonempty_q[nb_q]) prev_mem[hd_q] <= c_q;
        head_mem[nb_q] <= c_q;
        gb_mem[c_q] <= {1'b1, nb_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      nonempty_q <= '0;
      top_q <= '0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_CLEAR: clr_q <= clr_q + CW'(1);
        S_FIXUP: begin
          if (hd_q == c_q) begin
            if (!hnx) nonempty_q[ob_q] <= 1'b0;
          end
          cnt_q <= cnt_q - KW'(1);
        end
        S_SCAN: if (!(top_q == '0 || nonempty_q[top_q])) top_q <= top_q - BW'(1);
        S_LINK: begin
          nonempty_q[nb_q] <= 1'b1;
          cnt_q <= cnt_q + KW'(1);
          if (nb_q > top_q) top_q <= nb_q;
        end
        default: ;
      endcase
    end
  end

endmodule

[bench/gain_bucket_priority_list_tb.sv]
// ----------------------------------------------------------------------------
// Gain bucket priority list testbench
// Drives push, pop, move and query commands through the valid/stall handshake
// and compares every result beat with an in-bench model of the gain buckets.
// ----------------------------------------------------------------------------
module gain_bucket_priority_list_tb;
  import gbpl_pkg::*;

  localparam int NCELLS = 1024;
  localparam int GMAX   = 63;
  localparam int NBKT   = 2 * GMAX + 1;
  localparam int LIMIT  = 2000000;

  typedef struct packed {
    logic [IdW-1:0]     cell_no;
    logic               found;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
  } gain_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [CmdW-1:0]    cmd_i;
  logic [IdW-1:0]     cell_id_i;
  logic signed [GainW-1:0] gain_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [IdW-1:0]     result_cell_o;
  logic               found_o;
  logic [StatusW-1:0] status_o;
  logic [CountW-1:0]  total_count_o;

  // Bucket model: each bucket is a queue, index 0 is the head.
  int           bucket_q[NBKT][$];
  bit           held[NCELLS];
  int           held_gain[NCELLS];
  int           held_count;
  gain_result_t expected_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int mismatches;
  int beats_seen;
  int beats_sent;
  int cycles;

  gain_bucket_priority_list DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .cell_id_i, .gain_i,
    .out_valid_o, .out_stall_i, .result_cell_o, .found_o, .status_o,
    .total_count_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int clamp_gain(logic signed [GainW-1:0] g);
    int v;
    v = g;
    if (v > GMAX) v = GMAX;
    if (v < -GMAX) v = -GMAX;
    return v;
  endfunction

  function automatic void detach_cell(int c);
    int b;
    b = held_gain[c] + GMAX;
    foreach (bucket_q[b][i]) begin
      if (bucket_q[b][i] == c) begin
        bucket_q[b].delete(i);
        break;
      end
    end
    held[c] = 1'b0;
    held_count--;
  endfunction

  function automatic void attach_cell(int c, int g);
    bucket_q[g + GMAX].push_front(c);
    held[c] = 1'b1;
    held_gain[c] = g;
    held_count++;
  endfunction

  function automatic gain_result_t predict_bucket(cmd_e cmd, int c,
                                                  logic signed [GainW-1:0] g);
    gain_result_t r;
    int gv;
    int b;
    gv = clamp_gain(g);
    r.cell_no = c[IdW-1:0];
    r.found = 1'b0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (held[c]) r.status = ST_DUPLICATE;
        else attach_cell(c, gv);
      end
      CMD_POP: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (b = NBKT - 1; b >= 0; b--) begin
            if (bucket_q[b].size() != 0) break;
          end
          r.cell_no = bucket_q[b][0];
          detach_cell(bucket_q[b][0]);
        end
      end
      CMD_MOVE: begin
        if (!held[c]) begin
          r.status = ST_ABSENT;
        end else begin
          detach_cell(c);
          attach_cell(c, gv);
        end
      end
      default: r.found = held[c];
    endcase
    r.count = held_count[CountW-1:0];
    return r;
  endfunction

  task automatic send_command(cmd_e cmd, int c, int g);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    cell_id_i <= c[IdW-1:0];
    gain_i <= g[GainW-1:0];
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(predict_bucket(cmd, c, g[GainW-1:0]));
    beats_sent++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    gain_result_t got;
    gain_result_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{result_cell_o, found_o, status_o, total_count_o};
      beats_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          mismatches++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_directed();
    send_command(CMD_POP, 5, 0);
    send_command(CMD_MOVE, 7, 3);
    send_command(CMD_QUERY, 7, 0);
    send_command(CMD_PUSH, 0, 63);
    send_command(CMD_PUSH, 1023, -64);
    send_command(CMD_PUSH, 512, -63);
    send_command(CMD_PUSH, 3, 63);
    send_command(CMD_PUSH, 0, 5);
    send_command(CMD_QUERY, 1023, 0);
    send_command(CMD_MOVE, 3, 63);
    send_command(CMD_MOVE, 512, 10);
    send_command(CMD_POP, 0, 0);
    send_command(CMD_POP, 0, 0);
    send_command(CMD_POP, 0, 0);
    send_command(CMD_POP, 0, 0);
    send_command(CMD_POP, 0, 0);
    send_command(CMD_QUERY, 0, -1);
    send_command(CMD_PUSH, 682, 42);
    send_command(CMD_PUSH, 341, -43);
    send_command(CMD_POP, 0, 0);
    send_command(CMD_POP, 0, 0);
  endtask

  task automatic test_random(int n, int pool);
    int c;
    int pick;
    int g;
    for (int k = 0; k < n; k++) begin
      c = (pool == NCELLS) ? $urandom_range(NCELLS - 1) : $urandom_range(pool - 1);
      g = $urandom_range(5) == 0 ? $urandom_range(127) - 64 : $urandom_range(8) - 4;
      pick = $urandom_range(99);
      if (pick < 40) send_command(CMD_PUSH, c, g);
      else if (pick < 65) send_command(CMD_POP, c, g);
      else if (pick < 85) send_command(CMD_MOVE, c, g);
      else send_command(CMD_QUERY, c, g);
    end
  endtask

  initial begin
    errors = 0;
    mismatches = 0;
    beats_seen = 0;
    beats_sent = 0;
    cycles = 0;
    held_count = 0;
    set_idling(0, 0);
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    cmd_i <= CMD_QUERY;
    cell_id_i <= '0;
    gain_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(140, 64);
    set_idling(71, 0);
    test_random(130, 48);
    set_idling(0, 71);
    test_random(130, NCELLS);
    set_idling(34, 34);
    test_random(130, 32);
    drain_results();
    $display("Sent %0d commands and checked %0d result beats across four idling phases.",
             beats_sent, beats_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d errors, %0d mismatches", errors, mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
